// ----- design/cma_pkg.sv -----
// Package for the confusion matrix accuracy block: sizes, codes, types and helpers.
// Used by cma_div and the top level confusion_matrix_accuracy, which passes its sizes to cma_ram.
`default_nettype none
package cma_pkg;

	localparam int MAX_CLASSES = 16;
	localparam int CELL_BITS   = 40;
	localparam int NCOLS       = MAX_CLASSES + 1;
	localparam int DEPTH       = MAX_CLASSES * NCOLS;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int ROW_W       = $clog2(MAX_CLASSES);
	localparam int COL_W       = $clog2(NCOLS);
	localparam int CLS_W       = 5;
	localparam int CNT_W       = 31;
	localparam int TOTAL_W     = 48;
	localparam int RATIO_W     = 17;
	localparam int FRAC_W      = 16;
	localparam int SUM_RAW     = CELL_BITS + ADDR_W;
	localparam int SUM_W       = (SUM_RAW > TOTAL_W) ? SUM_RAW : TOTAL_W + 1;
	localparam int ACC_W       = RATIO_W + $clog2(MAX_CLASSES + 1);
	localparam int DVD_W       = (ACC_W > RATIO_W) ? ACC_W : RATIO_W;
	localparam int STEP_W      = $clog2(DVD_W + 1);
	localparam int CFG_IDX_W   = 2;

	localparam logic [1:0] MODE_CLEAR  = 2'd0;
	localparam logic [1:0] MODE_ACC    = 2'd1;
	localparam logic [1:0] MODE_READ   = 2'd2;
	localparam logic [1:0] MODE_REPORT = 2'd3;

	localparam logic [2:0] KIND_CELL    = 3'd0;
	localparam logic [2:0] KIND_ROW     = 3'd1;
	localparam logic [2:0] KIND_COL     = 3'd2;
	localparam logic [2:0] KIND_AVG_ACC = 3'd3;
	localparam logic [2:0] KIND_AVG_REL = 3'd4;
	localparam logic [2:0] KIND_OVERALL = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_ROW_CLASSES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COL_CLASSES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DIFF_DOM    = 2'd2;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_ACC_WR, S_CELL, S_WALK, S_WALK_END, S_FIN, S_DIV, S_EMIT
	} state_t;

	typedef enum logic [2:0] {
		PH_ROW, PH_COL, PH_AVG_ACC, PH_AVG_REL, PH_OVERALL
	} phase_t;

	typedef struct packed {
		logic start;
		logic avg;
	} div_req_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] c);
		return ADDR_W'(r) * ADDR_W'(NCOLS) + ADDR_W'(c);
	endfunction

	function automatic logic [TOTAL_W-1:0] sat_total(input logic [SUM_W-1:0] v);
		if (|v[SUM_W-1:TOTAL_W])
			return {TOTAL_W{1'b1}};
		return v[TOTAL_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ----- design/cma_ram.sv -----
// Generic single-port synchronous RAM with a registered read port.
// Holds the cell store of the confusion matrix; no package dependency.
`default_nettype none
module cma_ram #(
	parameter int DEPTH = 272,
	parameter int WIDTH = 40,
	parameter int AW    = 9
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic             re,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		if (re)
			rdata <= mem[addr];
	end
endmodule
`default_nettype wire

// ----- design/cma_div.sv -----
// Restoring divider, one quotient bit per cycle, for Q1.16 ratios and averages.
// Depends on cma_pkg for widths and the request struct.
`default_nettype none
module cma_div (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire cma_pkg::div_req_t       req,
	input  wire logic [cma_pkg::SUM_W-1:0] num,
	input  wire logic [cma_pkg::SUM_W-1:0] den,
	output logic                         done,
	output logic [cma_pkg::RATIO_W-1:0]  ratio
);
	import cma_pkg::*;

	localparam logic [DVD_W-1:0] ONE_Q = DVD_W'(1) << FRAC_W;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [SUM_W:0]    rem_q;
	logic [SUM_W-1:0]  den_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [DVD_W-1:0]  quo_q;
	logic [SUM_W:0]    shifted;
	logic [SUM_W:0]    diff;
	logic              ge;

	assign shifted = {rem_q[SUM_W-1:0], dvd_q[DVD_W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign ge      = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.avg ? STEP_W'(DVD_W) : STEP_W'(RATIO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// A ratio divides num * 2^16; the top of that dividend is num / 2, which
	// is already below the divisor, so only the last 17 bits need steps.
	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= den;
			quo_q <= '0;
			if (req.avg) begin
				rem_q <= '0;
				dvd_q <= DVD_W'(num);
			end else begin
				rem_q <= {2'b00, num[SUM_W-1:1]};
				dvd_q <= {num[0], {(DVD_W-1){1'b0}}};
			end
		end else if (busy_q) begin
			rem_q <= ge ? diff : shifted;
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign done  = done_q;
	assign ratio = (quo_q > ONE_Q) ? ONE_Q[RATIO_W-1:0] : quo_q[RATIO_W-1:0];
endmodule
`default_nettype wire

// ----- design/confusion_matrix_accuracy.sv -----
// Top level of the confusion matrix accumulator and accuracy reporter.
// Depends on cma_pkg, cma_ram (cell store) and cma_div (ratio divider).
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------
//   input    | in_valid / in_ready  | mode row_class row_defined col_class ...
//   output   | out_valid / out_ready| kind index total ratio ratio_defined last
//   config   | cfg_we               | cfg_index cfg_data
//
// Accumulate reads one memory cell, then writes it back with a saturating add.
// Read cell reads the cell, then waits for the output register to be free.
// Clear and the pass after reset sweep all 272 cells, one per cycle; no request
// is taken meanwhile. A report reads each active cell in the row pass and, if
// the domains match, in the column pass (one memory read a cycle), then runs
// the divider for each ratio. The output register lets a new request in while
// the last result still waits; a stalled output holds the report where it is.
`default_nettype none
module confusion_matrix_accuracy (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [cma_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [cma_pkg::CLS_W-1:0]   cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [1:0]                  mode,
	input  wire logic [cma_pkg::CLS_W-1:0]   row_class,
	input  wire logic                        row_defined,
	input  wire logic [cma_pkg::CLS_W-1:0]   col_class,
	input  wire logic                        col_defined,
	input  wire logic [cma_pkg::CNT_W-1:0]   count,
	input  wire logic                        count_defined,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [2:0]                       kind,
	output logic [cma_pkg::CLS_W-1:0]        index,
	output logic [cma_pkg::TOTAL_W-1:0]      total,
	output logic [cma_pkg::RATIO_W-1:0]      ratio,
	output logic                             ratio_defined,
	output logic                             last
);
	import cma_pkg::*;

	localparam logic [CLS_W-1:0] MAXC = CLS_W'(MAX_CLASSES);

	state_t state_q, state_d;
	phase_t phase_q;

	logic [CLS_W-1:0] row_classes_q, col_classes_q;
	logic             diff_dom_q;
	logic [CLS_W-1:0] nr, nc, walk_lim, outer_nx;
	logic [CLS_W-1:0] outer_q, inner_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic              rd_vld_s1, rd_diag_s1;

	logic [ADDR_W-1:0]    ram_addr, acc_addr_q;
	logic                 ram_we, ram_re;
	logic [CELL_BITS-1:0] ram_wdata, ram_rdata;
	logic [CELL_BITS:0]   acc_sum_wide;
	logic [CNT_W-1:0]     acc_cnt_q;

	logic [SUM_W-1:0]     sum_q, grand_q, diag_sum_q;
	logic [CELL_BITS-1:0] diag_cell_q;
	logic [ACC_W-1:0]     acc_sum_q, rel_sum_q;
	logic [CLS_W-1:0]     acc_n_q, rel_n_q;
	logic                 res_def_q;
	logic [CLS_W-1:0]     cell_row_q;
	logic                 cell_ok_q;

	logic       accept, acc_ok, cell_ok, out_free, emit, fin_def, row_more, col_more;
	logic [COL_W-1:0] acc_col;
	logic [ROW_W-1:0] walk_row;
	logic [COL_W-1:0] walk_col;
	div_req_t         div_req;
	logic [SUM_W-1:0] div_num, div_den;
	logic             div_done;
	logic [RATIO_W-1:0] div_ratio, res_ratio;

	assign nr = (row_classes_q > MAXC) ? MAXC : row_classes_q;
	assign nc = diff_dom_q ? ((col_classes_q > MAXC) ? MAXC : col_classes_q) : nr;
	assign walk_lim = (phase_q == PH_ROW) ? nc + CLS_W'(1) : nr;
	assign outer_nx = outer_q + CLS_W'(1);
	assign row_more = outer_nx < nr;
	assign col_more = outer_nx < nc;
	assign out_free = !out_valid || out_ready;
	assign accept   = in_valid && in_ready;

	assign acc_ok  = row_defined && count_defined && (row_class < nr) &&
		(!col_defined || (col_class < nc));
	assign acc_col = col_defined ? col_class[COL_W-1:0] : nc[COL_W-1:0];
	assign cell_ok = (row_class < nr) && (col_class <= nc);

	assign walk_row = (phase_q == PH_ROW) ? outer_q[ROW_W-1:0] : inner_q[ROW_W-1:0];
	assign walk_col = (phase_q == PH_ROW) ? inner_q[COL_W-1:0] : outer_q[COL_W-1:0];

	always_comb begin
		fin_def = 1'b0;
		div_num = SUM_W'(diag_cell_q);
		div_den = sum_q;
		case (phase_q)
			PH_ROW:     fin_def = !diff_dom_q && (sum_q != '0);
			PH_COL:     fin_def = sum_q != '0;
			PH_AVG_ACC: begin
				fin_def = acc_n_q != '0;
				div_num = SUM_W'(acc_sum_q);
				div_den = SUM_W'(acc_n_q);
			end
			PH_AVG_REL: begin
				fin_def = rel_n_q != '0;
				div_num = SUM_W'(rel_sum_q);
				div_den = SUM_W'(rel_n_q);
			end
			PH_OVERALL: begin
				fin_def = grand_q != '0;
				div_num = diag_sum_q;
				div_den = grand_q;
			end
			default: fin_def = 1'b0;
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (clr_addr_q == ADDR_W'(DEPTH - 1)) state_d = S_IDLE;
			S_IDLE: begin
				if (in_valid) begin
					case (mode)
						MODE_CLEAR:  state_d = S_CLEAR;
						MODE_ACC:    state_d = acc_ok ? S_ACC_WR : S_IDLE;
						MODE_READ:   state_d = S_CELL;
						MODE_REPORT: begin
							if (nr != '0)
								state_d = S_WALK;
							else
								state_d = diff_dom_q ? S_IDLE : S_FIN;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_ACC_WR:   state_d = S_IDLE;
			S_CELL:     if (out_free) state_d = S_IDLE;
			S_WALK:     if (inner_q == walk_lim - CLS_W'(1)) state_d = S_WALK_END;
			S_WALK_END: state_d = S_FIN;
			S_FIN:      state_d = fin_def ? S_DIV : S_EMIT;
			S_DIV:      if (div_done) state_d = S_EMIT;
			S_EMIT: begin
				if (out_free) begin
					case (phase_q)
						PH_ROW:     state_d = (row_more || !diff_dom_q) ? S_WALK : S_IDLE;
						PH_COL:     state_d = col_more ? S_WALK : S_FIN;
						PH_AVG_ACC: state_d = S_FIN;
						PH_AVG_REL: state_d = S_FIN;
						PH_OVERALL: state_d = S_IDLE;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs of the state machine.
	always_comb begin
		in_ready     = 1'b0;
		ram_we       = 1'b0;
		ram_re       = 1'b0;
		ram_addr     = cell_addr(walk_row, walk_col);
		ram_wdata    = '0;
		emit         = 1'b0;
		div_req      = '0;
		acc_sum_wide = {1'b0, ram_rdata} + (CELL_BITS + 1)'(acc_cnt_q);
		case (state_q)
			S_CLEAR: begin
				ram_we   = 1'b1;
				ram_addr = clr_addr_q;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				ram_re   = in_valid && ((mode == MODE_ACC) || (mode == MODE_READ));
				ram_addr = cell_addr(row_class[ROW_W-1:0],
					(mode == MODE_ACC) ? acc_col : col_class[COL_W-1:0]);
			end
			S_ACC_WR: begin
				ram_we    = 1'b1;
				ram_addr  = acc_addr_q;
				ram_wdata = acc_sum_wide[CELL_BITS] ? {CELL_BITS{1'b1}} :
					acc_sum_wide[CELL_BITS-1:0];
			end
			S_CELL:  emit = out_free;
			S_WALK:  ram_re = 1'b1;
			S_FIN:   div_req = '{start: fin_def,
				avg: (phase_q == PH_AVG_ACC) || (phase_q == PH_AVG_REL)};
			S_EMIT:  emit = out_free;
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			phase_q       <= PH_ROW;
			row_classes_q <= CLS_W'(16);
			col_classes_q <= CLS_W'(16);
			diff_dom_q    <= 1'b0;
			clr_addr_q    <= '0;
			outer_q       <= '0;
			inner_q       <= '0;
			rd_vld_s1     <= 1'b0;
			out_valid     <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= state_q == S_WALK;
			if (cfg_we) begin
				case (cfg_index)
					CFG_ROW_CLASSES: row_classes_q <= cfg_data;
					CFG_COL_CLASSES: col_classes_q <= cfg_data;
					CFG_DIFF_DOM:    diff_dom_q    <= cfg_data[0];
					default:         diff_dom_q    <= diff_dom_q;
				endcase
			end
			if (state_q == S_CLEAR)
				clr_addr_q <= (clr_addr_q == ADDR_W'(DEPTH - 1)) ? '0 :
					clr_addr_q + ADDR_W'(1);
			if (accept && (mode == MODE_REPORT)) begin
				phase_q <= (nr == '0) ? PH_AVG_ACC : PH_ROW;
				outer_q <= '0;
				inner_q <= '0;
			end
			if (state_q == S_WALK)
				inner_q <= inner_q + CLS_W'(1);
			if (state_q == S_EMIT && out_free) begin
				inner_q <= '0;
				case (phase_q)
					PH_ROW: begin
						if (row_more) begin
							outer_q <= outer_nx;
						end else begin
							outer_q <= '0;
							phase_q <= PH_COL;
						end
					end
					PH_COL: begin
						if (col_more)
							outer_q <= outer_nx;
						else
							phase_q <= PH_AVG_ACC;
					end
					PH_AVG_ACC: phase_q <= PH_AVG_REL;
					PH_AVG_REL: phase_q <= PH_OVERALL;
					default:    phase_q <= phase_q;
				endcase
			end
			if (emit)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

	assign res_ratio = res_def_q ? div_ratio : '0;

	always_ff @(posedge clk) begin
		rd_diag_s1 <= inner_q == outer_q;
		if (accept) begin
			acc_addr_q <= ram_addr;
			acc_cnt_q  <= count;
			cell_row_q <= row_class;
			cell_ok_q  <= cell_ok;
			grand_q    <= '0;
			diag_sum_q <= '0;
			acc_sum_q  <= '0;
			rel_sum_q  <= '0;
			acc_n_q    <= '0;
			rel_n_q    <= '0;
		end
		if ((accept && (mode == MODE_REPORT)) || (state_q == S_EMIT && out_free)) begin
			sum_q       <= '0;
			diag_cell_q <= '0;
		end else if (rd_vld_s1) begin
			sum_q <= sum_q + SUM_W'(ram_rdata);
			if (rd_diag_s1)
				diag_cell_q <= ram_rdata;
		end
		if (state_q == S_FIN)
			res_def_q <= fin_def;
		if (state_q == S_EMIT && out_free) begin
			case (phase_q)
				PH_ROW: begin
					grand_q    <= grand_q + sum_q;
					diag_sum_q <= diag_sum_q + SUM_W'(diag_cell_q);
					if (res_def_q) begin
						acc_sum_q <= acc_sum_q + ACC_W'(div_ratio);
						acc_n_q   <= acc_n_q + CLS_W'(1);
					end
				end
				PH_COL: begin
					if (res_def_q) begin
						rel_sum_q <= rel_sum_q + ACC_W'(div_ratio);
						rel_n_q   <= rel_n_q + CLS_W'(1);
					end
				end
				default: grand_q <= grand_q;
			endcase
		end
		if (emit) begin
			if (state_q == S_CELL) begin
				kind          <= KIND_CELL;
				index         <= cell_row_q;
				total         <= cell_ok_q ? TOTAL_W'(ram_rdata) : '0;
				ratio         <= '0;
				ratio_defined <= 1'b0;
				last          <= 1'b1;
			end else begin
				ratio         <= res_ratio;
				ratio_defined <= res_def_q;
				index         <= '0;
				total         <= '0;
				last          <= 1'b0;
				case (phase_q)
					PH_ROW: begin
						kind  <= KIND_ROW;
						index <= outer_q;
						total <= sat_total(sum_q);
						last  <= diff_dom_q && !row_more;
					end
					PH_COL: begin
						kind  <= KIND_COL;
						index <= outer_q;
						total <= sat_total(sum_q);
					end
					PH_AVG_ACC: kind <= KIND_AVG_ACC;
					PH_AVG_REL: kind <= KIND_AVG_REL;
					default: begin
						kind  <= KIND_OVERALL;
						total <= sat_total(grand_q);
						last  <= 1'b1;
					end
				endcase
			end
		end
	end

	cma_ram #(.DEPTH(DEPTH), .WIDTH(CELL_BITS), .AW(ADDR_W)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	cma_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.ratio  (div_ratio)
	);

	// An accepted record is written back in the very next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (mode == MODE_ACC) && acc_ok) |=> (state_q == S_ACC_WR) && ram_we)
		else $error("accumulate write-back missing");

	// Read data is only summed while a walk is in flight.
	assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == S_WALK) || (state_q == S_WALK_END))
		else $error("stray read data in walk accumulator");

	// The diagonal cell never exceeds its row sum, which the divider relies on.
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_FIN) && (phase_q == PH_ROW)) |-> (sum_q >= SUM_W'(diag_cell_q)))
		else $error("diagonal exceeds row sum");

	// Writes stay inside the cell store.
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (ram_addr < ADDR_W'(DEPTH)))
		else $error("cell store write out of range");
endmodule
`default_nettype wire
